### rtl/u2u8_pkg.sv
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps

package u2u8_pkg;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [20:0] LIM_ONE    = 21'h80;
  localparam logic [20:0] LIM_TWO    = 21'h800;
  localparam logic [20:0] LIM_THREE  = 21'h10000;

  localparam logic [2:0] LEAD2 = 3'b110;
  localparam logic [3:0] LEAD3 = 4'b1110;
  localparam logic [4:0] LEAD4 = 5'b11110;
  localparam logic [1:0] CONT  = 2'b10;

  localparam int MAX_BYTES = 6;

  typedef struct packed {
    logic [0:3][7:0] b;
    logic [2:0]      n;
  } enc_t;

  typedef struct packed {
    logic [0:MAX_BYTES-1][7:0] data;
    logic [2:0]                count;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] high;
  } hold_t;

  function automatic enc_t u2u8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < LIM_ONE) begin
      e.b[0] = cp[7:0];
      e.n    = 3'd1;
    end else if (cp < LIM_TWO) begin
      e.b[0] = {LEAD2, cp[10:6]};
      e.b[1] = {CONT, cp[5:0]};
      e.n    = 3'd2;
    end else if (cp < LIM_THREE) begin
      e.b[0] = {LEAD3, cp[15:12]};
      e.b[1] = {CONT, cp[11:6]};
      e.b[2] = {CONT, cp[5:0]};
      e.n    = 3'd3;
    end else begin
      e.b[0] = {LEAD4, cp[20:18]};
      e.b[1] = {CONT, cp[17:12]};
      e.b[2] = {CONT, cp[11:6]};
      e.b[3] = {CONT, cp[5:0]};
      e.n    = 3'd4;
    end
    return e;
  endfunction

endpackage

### rtl/u2u8_in_if.sv
// Code unit request channel.
`timescale 1ns / 1ps

interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

### rtl/u2u8_out_if.sv
// UTF-8 byte request channel.
`timescale 1ns / 1ps

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_end, input string_end,
                output ready);
endinterface

### rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level.
//
// units:  UTF-16 code units with last_unit marking the final unit of a string.
// octets: UTF-8 bytes, one per request, with run_end on the last byte caused by
//         an input unit and string_end on the final byte of the string.
// A high surrogate that is not a string's last unit is held until the next
// unit; a following low surrogate makes a 4-byte sequence, otherwise the
// held unit goes out alone as 3 bytes. A unit's first byte passes the byte
// list register, then the output register. Throughput: one byte per cycle
// while octets does not stall, set by the single output register; a unit
// yields 1 to 6 bytes (usually 1 to 3) and a held-only unit loads none. The
// next unit is taken in the cycle the last byte of the current one moves to
// the output register. Reset clears the held surrogate, the byte list and
// the output valid. When the receiver stalls, the output byte holds, the
// byte list waits, and units is held off once the list is still pending.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder (
  input  logic       clk,
  input  logic       rst,
  u2u8_in_if.sink    units,
  u2u8_out_if.source octets
);
  import u2u8_pkg::*;

  hold_t held;
  hold_t held_next;
  job_t  job;
  logic  free;
  logic  accept;
  logic  load;

  assign units.ready = free;
  assign accept      = units.valid && free;
  assign load        = accept && (job.count != 3'd0);

  u2u8_decode u_decode (
    .code_unit (units.code_unit),
    .last_unit (units.last_unit),
    .held      (held),
    .job       (job),
    .held_next (held_next)
  );

  u2u8_serializer u_serializer (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .job_in (job),
    .free   (free),
    .octets (octets)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (accept) begin
      held <= held_next;
    end
  end

endmodule

### rtl/u2u8_decode.sv
// Surrogate pairing and UTF-8 byte list build for one code unit.
`timescale 1ns / 1ps

module u2u8_decode (
  input  logic [15:0]    code_unit,
  input  logic           last_unit,
  input  u2u8_pkg::hold_t held,
  output u2u8_pkg::job_t  job,
  output u2u8_pkg::hold_t held_next
);
  import u2u8_pkg::*;

  logic is_high;
  logic is_low;
  enc_t enc_pair;
  enc_t enc_held;
  enc_t enc_unit;

  assign is_high = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
  assign is_low  = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);

  assign enc_pair = u2u8_encode(SUPP_BASE + {1'b0, held.high[9:0], code_unit[9:0]});
  assign enc_held = u2u8_encode({5'd0, held.high});
  assign enc_unit = u2u8_encode({5'd0, code_unit});

  always_comb begin
    job       = '0;
    held_next = '0;
    job.last  = last_unit;
    if (held.valid && is_low) begin
      for (int i = 0; i < 4; i++) job.data[i] = enc_pair.b[i];
      job.count = enc_pair.n;
    end else begin
      if (held.valid) begin
        for (int i = 0; i < 3; i++) job.data[i] = enc_held.b[i];
        job.count = 3'd3;
      end
      if (is_high && !last_unit) begin
        held_next.valid = 1'b1;
        held_next.high  = code_unit;
      end else if (held.valid) begin
        // unit after a flushed high surrogate is below 0x10000: at most 3 bytes
        for (int i = 0; i < 3; i++) job.data[3 + i] = enc_unit.b[i];
        job.count = 3'd3 + enc_unit.n;
      end else begin
        for (int i = 0; i < 4; i++) job.data[i] = enc_unit.b[i];
        job.count = enc_unit.n;
      end
    end
  end

endmodule

### rtl/u2u8_serializer.sv
// Byte list register and output register; sends one byte per cycle while the output is not stalled.
`timescale 1ns / 1ps

module u2u8_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  u2u8_pkg::job_t  job_in,
  output logic           free,
  u2u8_out_if.source     octets
);
  import u2u8_pkg::*;

  job_t       job;
  logic       job_valid;
  logic [2:0] idx;
  logic       out_free;
  logic       send;
  logic       at_end;
  logic       job_done;

  assign out_free = !octets.valid || octets.ready;
  assign send     = job_valid && out_free;
  assign at_end   = (idx == job.count - 3'd1);
  assign job_done = send && at_end;
  assign free     = !job_valid || job_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (job_done) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (send) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) job <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octets.valid <= 1'b0;
    end else if (out_free) begin
      octets.valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      octets.out_byte   <= job.data[idx];
      octets.run_end    <= at_end;
      octets.string_end <= at_end && job.last;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> (idx < job.count))
    else $error("byte index past end of list");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!job_valid || job_done))
    else $error("byte list overwritten before sent");

  a_done_marks_run: assert property (@(posedge clk) disable iff (rst)
    job_done |=> (octets.valid && octets.run_end))
    else $error("last byte of list lacks run_end");

  a_string_end_on_run: assert property (@(posedge clk) disable iff (rst)
    (octets.valid && octets.string_end) |-> octets.run_end)
    else $error("string_end without run_end");

endmodule

### test/tb_utf16_to_utf8_transcoder.sv
// Testbench for the UTF-16 to UTF-8 transcoder: directed cases and random strings checked against a byte predictor.
`timescale 1ns / 1ps

module tb_utf16_to_utf8_transcoder;
  import u2u8_pkg::*;

  typedef struct {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_req_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } utf8_byte_t;

  typedef enum int {
    PHASE_FREE,
    PHASE_SRC_IDLE,
    PHASE_SNK_STALL,
    PHASE_BOTH
  } phase_t;

  logic clk;
  logic rst;

  u2u8_in_if  units_if ();
  u2u8_out_if octets_if ();

  utf16_to_utf8_transcoder dut (
    .clk    (clk),
    .rst    (rst),
    .units  (units_if),
    .octets (octets_if)
  );

  unit_req_t  pending_units[$];
  utf8_byte_t expected_bytes[$];
  logic [7:0] run_bytes[$];

  logic [15:0] held_surrogate;
  logic        surrogate_held;
  logic        unit_taken;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          mismatches;
  int          units_queued;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch %s: got %02h expected %02h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_unit(input logic [15:0] cu, input logic last);
    unit_req_t u;
    u.code_unit = cu;
    u.last_unit = last;
    pending_units.push_back(u);
    units_queued++;
  endtask

  task automatic encode_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      run_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      run_bytes.push_back(8'hC0 | {3'b0, cp[10:6]});
      run_bytes.push_back(8'h80 | {2'b0, cp[5:0]});
    end else if (cp < 21'h10000) begin
      run_bytes.push_back(8'hE0 | {4'b0, cp[15:12]});
      run_bytes.push_back(8'h80 | {2'b0, cp[11:6]});
      run_bytes.push_back(8'h80 | {2'b0, cp[5:0]});
    end else begin
      run_bytes.push_back(8'hF0 | {5'b0, cp[20:18]});
      run_bytes.push_back(8'h80 | {2'b0, cp[17:12]});
      run_bytes.push_back(8'h80 | {2'b0, cp[11:6]});
      run_bytes.push_back(8'h80 | {2'b0, cp[5:0]});
    end
  endtask

  task automatic predict_unit(input logic [15:0] cu, input logic last);
    logic       is_high;
    logic       is_low;
    logic [20:0] cp;
    utf8_byte_t b;
    is_high = (cu >= HIGH_FIRST) && (cu <= HIGH_LAST);
    is_low  = (cu >= LOW_FIRST) && (cu <= LOW_LAST);
    run_bytes.delete();
    if (surrogate_held && is_low) begin
      cp = 21'h10000 + ({5'b0, held_surrogate - HIGH_FIRST} << 10)
           + {5'b0, cu - LOW_FIRST};
      encode_code_point(cp);
      surrogate_held = 1'b0;
      held_surrogate = '0;
    end else begin
      if (surrogate_held) begin
        encode_code_point({5'b0, held_surrogate});
        surrogate_held = 1'b0;
        held_surrogate = '0;
      end
      if (is_high && !last) begin
        held_surrogate = cu;
        surrogate_held = 1'b1;
      end else begin
        encode_code_point({5'b0, cu});
      end
    end
    for (int i = 0; i < run_bytes.size(); i++) begin
      b.out_byte   = run_bytes[i];
      b.run_end    = (i == run_bytes.size() - 1);
      b.string_end = b.run_end && last;
      expected_bytes.push_back(b);
    end
  endtask

  // mostly well-formed text, with broken surrogates and raw noise mixed in
  task automatic add_string(input int len);
    int          pick;
    logic [15:0] cu;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        cu = 16'($urandom_range(16'h007F));
      end else if (pick < 35) begin
        cu = 16'($urandom_range(16'h07FF, 16'h0080));
      end else if (pick < 55) begin
        cu = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h0800))
                               : 16'($urandom_range(16'hFFFF, 16'hE000));
      end else if (pick < 80) begin
        cu = 16'($urandom_range(HIGH_LAST, HIGH_FIRST));
        if (i + 1 < len) begin
          push_unit(cu, 1'b0);
          i++;
          cu = 16'($urandom_range(LOW_LAST, LOW_FIRST));
        end
      end else if (pick < 87) begin
        cu = 16'($urandom_range(HIGH_LAST, HIGH_FIRST));
      end else if (pick < 93) begin
        cu = 16'($urandom_range(LOW_LAST, LOW_FIRST));
      end else begin
        cu = 16'($urandom_range(16'hFFFF));
      end
      push_unit(cu, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_units.size() != 0 || units_if.valid || expected_bytes.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input phase_t ph, input int count);
    int target;
    case (ph)
      PHASE_FREE: begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
      end
      PHASE_SRC_IDLE: begin
        src_idle_pct = 69;
        snk_stall_pct = 0;
      end
      PHASE_SNK_STALL: begin
        src_idle_pct = 0;
        snk_stall_pct = 69;
      end
      default: begin
        src_idle_pct = 22;
        snk_stall_pct = 22;
      end
    endcase
    target = units_queued + count;
    while (units_queued < target) begin
      if ($urandom_range(9) == 0)
        add_string(1);
      else
        add_string($urandom_range(8, 2));
    end
    wait_drained();
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      units_if.valid <= 1'b0;
      octets_if.ready <= 1'b0;
    end else begin
      if (!units_if.valid || unit_taken) begin
        if (pending_units.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          units_if.valid     <= 1'b1;
          units_if.code_unit <= pending_units[0].code_unit;
          units_if.last_unit <= pending_units[0].last_unit;
          void'(pending_units.pop_front());
        end else begin
          units_if.valid <= 1'b0;
        end
      end
      octets_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst) begin
      unit_taken <= 1'b0;
    end else begin
      unit_taken <= units_if.valid && units_if.ready;
      if (units_if.valid && units_if.ready)
        predict_unit(units_if.code_unit, units_if.last_unit);
      if (octets_if.valid && octets_if.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected byte", octets_if.out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (octets_if.out_byte !== want.out_byte)
            report_mismatch("out_byte", octets_if.out_byte, want.out_byte);
          if (octets_if.run_end !== want.run_end)
            report_mismatch("run_end", {7'b0, octets_if.run_end}, {7'b0, want.run_end});
          if (octets_if.string_end !== want.string_end)
            report_mismatch("string_end", {7'b0, octets_if.string_end},
                            {7'b0, want.string_end});
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL utf16_to_utf8_transcoder");
    $finish;
  end

  initial begin
    rst = 1'b1;
    units_if.valid = 1'b0;
    units_if.code_unit = '0;
    units_if.last_unit = 1'b0;
    octets_if.ready = 1'b0;
    unit_taken = 1'b0;
    held_surrogate = '0;
    surrogate_held = 1'b0;
    mismatches = 0;
    units_queued = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // field extremes and every boundary of the byte count
    push_unit(16'h0000, 1'b1);
    push_unit(16'h007F, 1'b1);
    push_unit(16'h0080, 1'b0);
    push_unit(16'h07FF, 1'b1);
    push_unit(16'h0800, 1'b0);
    push_unit(16'hD7FF, 1'b0);
    push_unit(16'hE000, 1'b0);
    push_unit(16'hFFFF, 1'b1);
    // surrogate pairs, lowest and highest
    push_unit(16'hD800, 1'b0);
    push_unit(16'hDC00, 1'b1);
    push_unit(16'hDBFF, 1'b0);
    push_unit(16'hDFFF, 1'b1);
    // lone low surrogates
    push_unit(16'hDC00, 1'b1);
    push_unit(16'hDFFF, 1'b0);
    push_unit(16'h0041, 1'b1);
    // held high flushed by a non-low unit: six bytes from one request
    push_unit(16'hD800, 1'b0);
    push_unit(16'hFFFF, 1'b1);
    // high, high, low
    push_unit(16'hDA12, 1'b0);
    push_unit(16'hDB34, 1'b0);
    push_unit(16'hDE56, 1'b1);
    // high surrogate as the last unit, alone and after a held one
    push_unit(16'hDBFF, 1'b1);
    push_unit(16'hD801, 1'b0);
    push_unit(16'hDBFE, 1'b1);
    push_unit(16'hD9AA, 1'b0);
    push_unit(16'h0000, 1'b1);
    wait_drained();

    run_phase(PHASE_FREE, 75);
    run_phase(PHASE_SRC_IDLE, 75);
    run_phase(PHASE_SNK_STALL, 75);
    run_phase(PHASE_BOTH, 75);

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("PASS utf16_to_utf8_transcoder");
    else
      $display("FAIL utf16_to_utf8_transcoder");
    $finish;
  end

endmodule
